// File: hw/rtl/t8cpu_pkg.sv
// Package for the tiny 8-bit CPU execute unit: opcodes, error codes, sizes,
// controller/datapath command and status structs. No dependencies.
package t8cpu_pkg;

    localparam int MEM_DEPTH   = 64;
    localparam int STACK_DEPTH = 8;
    localparam int NUM_REGS    = 8;
    localparam int MEM_AW      = $clog2(MEM_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int STK_AW      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    localparam logic [4:0] OP_MOVRR   = 5'd0;
    localparam logic [4:0] OP_MOVIMM  = 5'd1;
    localparam logic [4:0] OP_MOVIND  = 5'd2;
    localparam logic [4:0] OP_RESET   = 5'd3;
    localparam logic [4:0] OP_ADD     = 5'd4;
    localparam logic [4:0] OP_SUB     = 5'd5;
    localparam logic [4:0] OP_MUL     = 5'd6;
    localparam logic [4:0] OP_DIV     = 5'd7;
    localparam logic [4:0] OP_INC     = 5'd8;
    localparam logic [4:0] OP_DEC     = 5'd9;
    localparam logic [4:0] OP_SHL     = 5'd10;
    localparam logic [4:0] OP_SHR     = 5'd11;
    localparam logic [4:0] OP_ROL     = 5'd12;
    localparam logic [4:0] OP_ROR     = 5'd13;
    localparam logic [4:0] OP_INPUT   = 5'd14;
    localparam logic [4:0] OP_DISPLAY = 5'd15;
    localparam logic [4:0] OP_LDD     = 5'd16;
    localparam logic [4:0] OP_LDI     = 5'd17;
    localparam logic [4:0] OP_STD     = 5'd18;
    localparam logic [4:0] OP_STI     = 5'd19;
    localparam logic [4:0] OP_PUSH    = 5'd20;
    localparam logic [4:0] OP_POP     = 5'd21;

    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_STACK_OVER  = 3'd1;
    localparam logic [2:0] ERR_STACK_UNDER = 3'd2;
    localparam logic [2:0] ERR_DIV_ZERO    = 3'd3;
    localparam logic [2:0] ERR_BAD_ADDR    = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic capture;     // latch instruction, read operands
        logic div_start;   // launch divider
        logic commit;      // write back results
        logic clear_step;  // memory clear sweep write
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_div;
        logic div_busy;
        logic clear_done;
    } dp_stat_t;

endpackage

// File: hw/rtl/t8cpu_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module t8cpu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// File: hw/rtl/t8cpu_div.sv
// Restoring signed divider, one quotient bit per cycle, C truncation.
// Dividend is 8-bit signed, divisor 16-bit signed. Depends on nothing.
module t8cpu_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [7:0]  dividend,
    input  logic signed [15:0] divisor,
    output logic               busy,
    output logic signed [8:0]  quotient
);
    logic [3:0]  cnt_reg;
    logic [7:0]  q_reg;
    logic [16:0] rem_reg;
    logic [15:0] dvs_reg;
    logic        neg_reg;
    logic [16:0] trial;

    assign trial    = {rem_reg[15:0], q_reg[7]} - {1'b0, dvs_reg};
    assign busy     = (cnt_reg != 4'd0);
    assign quotient = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 4'd0;
        end
        else if (start)
        begin
            cnt_reg <= 4'd8;
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 4'd1;
        end
    end

    // one shift-subtract step per cycle, quotient bits enter at the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend[7] ? 8'(-dividend) : dividend;
            rem_reg <= 17'd0;
            dvs_reg <= divisor[15] ? 16'(-divisor) : divisor;
            neg_reg <= dividend[7] ^ divisor[15];
        end
        else if (busy)
        begin
            if (!trial[16])
            begin
                rem_reg <= trial;
                q_reg   <= {q_reg[6:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[15:0], q_reg[7]};
                q_reg   <= {q_reg[6:0], 1'b0};
            end
        end
    end
endmodule

// File: hw/rtl/t8cpu_datapath.sv
// Datapath: register file, flags, data memory, stack, PC, ALU, divider.
// Depends on t8cpu_pkg, t8cpu_ram, t8cpu_div.
module t8cpu_datapath
    import t8cpu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_stat_t           stat,
    input  logic [4:0]         op,
    input  logic [2:0]         dest_reg,
    input  logic [2:0]         src_reg,
    input  logic               use_imm,
    input  logic signed [15:0] imm,
    input  logic [7:0]         mem_addr,
    input  logic [3:0]         shift_amount,
    input  logic [1:0]         flag_select,
    input  logic signed [15:0] input_value,
    output logic               display_valid,
    output logic signed [7:0]  display_value,
    output logic               carry_flag,
    output logic               zero_flag,
    output logic               overflow_flag,
    output logic               underflow_flag,
    output logic [2:0]         error_code,
    output logic               halted,
    output logic [15:0]        program_counter
);
    // captured instruction
    logic [4:0]         op_reg;
    logic [2:0]         rd_reg;
    logic [3:0]         amt_reg;
    logic [1:0]         fsel_reg;
    logic signed [15:0] inval_reg;
    logic signed [15:0] imm_reg;
    logic [7:0]         maddr_reg;
    logic signed [7:0]  a_reg;
    logic signed [15:0] b_reg;
    logic signed [7:0]  ind_reg;

    logic signed [7:0]  rf_reg [NUM_REGS];
    logic [SP_W-1:0]    sp_reg;
    logic [MEM_AW:0]    clr_reg;
    logic               clr_busy;

    // memories
    logic [MEM_AW-1:0]  mem_a;
    logic               mem_we;
    logic [7:0]         mem_wd, mem_rd;
    logic [STK_AW-1:0]  stk_a;
    logic               stk_we;
    logic [7:0]         stk_rd;
    logic signed [8:0]  quo;
    logic               div_busy;

    // executed result; 24 bits hold the widest product and shift
    logic signed [23:0] res;
    logic [8:0]         sum9;
    logic [7:0]         bop;
    logic               set_f, load_cls, wr_rd;
    logic [2:0]         err;
    logic [7:0]         rot;
    logic [2:0]         rn;
    logic               dir_ok, ind_ok;
    logic               show;

    assign dir_ok = (maddr_reg < 8'(MEM_DEPTH));
    assign ind_ok = !ind_reg[7] && ({1'b0, ind_reg[6:0]} < 8'(MEM_DEPTH));
    assign clr_busy = (clr_reg != (MEM_AW+1)'(MEM_DEPTH));
    assign show = !halted && (err == ERR_NONE) && (op_reg == OP_DISPLAY);

    // memory address mux: sweep, load/store
    always_comb
    begin
        mem_we = 1'b0;
        mem_wd = a_reg;
        if (clr_busy)
        begin
            mem_a  = clr_reg[MEM_AW-1:0];
            mem_we = cmd.clear_step;
            mem_wd = 8'd0;
        end
        else if (op_reg == OP_LDD || op_reg == OP_STD)
        begin
            mem_a  = maddr_reg[MEM_AW-1:0];
            mem_we = cmd.commit && (op_reg == OP_STD) && dir_ok && !halted;
        end
        else
        begin
            mem_a  = MEM_AW'(ind_reg[6:0]);
            mem_we = cmd.commit && (op_reg == OP_STI) && ind_ok && !halted;
        end
    end

    always_comb
    begin
        if (op_reg == OP_PUSH)
        begin
            stk_a = STK_AW'(sp_reg);
        end
        else
        begin
            stk_a = STK_AW'(sp_reg - SP_W'(1));
        end
    end
    assign stk_we = cmd.commit && !halted && (op_reg == OP_PUSH)
                    && (sp_reg < SP_W'(STACK_DEPTH));

    t8cpu_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_mem (
        .clk(clk), .we(mem_we), .addr(mem_a), .wdata(mem_wd), .rdata(mem_rd)
    );
    t8cpu_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stk (
        .clk(clk), .we(stk_we), .addr(stk_a), .wdata(a_reg), .rdata(stk_rd)
    );
    t8cpu_div u_div (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dividend(a_reg),
        .divisor(b_reg), .busy(div_busy), .quotient(quo)
    );

    assign stat.is_div     = (op_reg == OP_DIV);
    assign stat.div_busy   = div_busy;
    assign stat.clear_done = !clr_busy;

    // rotate
    always_comb
    begin
        rn = amt_reg[2:0];
        if (op_reg == OP_ROL)
        begin
            rot = 8'({a_reg, a_reg} >> (4'd8 - {1'b0, rn}));
        end
        else
        begin
            rot = 8'({a_reg, a_reg} >> rn);
        end
    end

    // ALU: full-width result plus CF operand sum
    always_comb
    begin
        res      = 24'sd0;
        bop      = 8'd0;
        set_f    = 1'b0;
        load_cls = 1'b0;
        wr_rd    = 1'b0;
        err      = ERR_NONE;
        case (op_reg)
            OP_MOVRR:
            begin
                res = 24'(b_reg); load_cls = 1'b1; wr_rd = 1'b1;
            end
            OP_MOVIMM:
            begin
                res = 24'(imm_reg); load_cls = 1'b1; wr_rd = 1'b1;
            end
            OP_MOVIND, OP_LDI:
            begin
                if (!ind_ok) err = ERR_BAD_ADDR;
                res = 24'($signed(mem_rd)); load_cls = 1'b1; wr_rd = 1'b1;
            end
            OP_LDD:
            begin
                if (!dir_ok) err = ERR_BAD_ADDR;
                res = 24'($signed(mem_rd)); load_cls = 1'b1; wr_rd = 1'b1;
            end
            OP_ADD:
            begin
                res = 24'(a_reg) + 24'(b_reg); bop = b_reg[7:0];
                set_f = 1'b1; wr_rd = 1'b1;
            end
            OP_SUB:
            begin
                res = 24'(a_reg) - 24'(b_reg); bop = 8'(-b_reg[7:0]);
                set_f = 1'b1; wr_rd = 1'b1;
            end
            OP_MUL:
            begin
                res = 24'(a_reg) * 24'(b_reg); bop = b_reg[7:0];
                set_f = 1'b1; wr_rd = 1'b1;
            end
            OP_DIV:
            begin
                if (b_reg == 16'sd0) err = ERR_DIV_ZERO;
                res = 24'(quo); bop = b_reg[7:0];
                set_f = 1'b1; wr_rd = 1'b1;
            end
            OP_INC:
            begin
                res = 24'(a_reg) + 24'sd1; bop = 8'd1; set_f = 1'b1; wr_rd = 1'b1;
            end
            OP_DEC:
            begin
                res = 24'(a_reg) - 24'sd1; bop = 8'hFF; set_f = 1'b1; wr_rd = 1'b1;
            end
            OP_SHL:
            begin
                // count up to 15 still fits: |a| * 2^15 <= 2^22
                res = 24'(a_reg) <<< amt_reg;
                set_f = 1'b1; wr_rd = 1'b1;
            end
            OP_SHR:
            begin
                res = 24'({1'b0, a_reg} >> amt_reg); set_f = 1'b1; wr_rd = 1'b1;
            end
            OP_ROL, OP_ROR:
            begin
                res = 24'($signed(rot)); set_f = 1'b1; wr_rd = 1'b1;
            end
            OP_INPUT:
            begin
                if (inval_reg > 16'sd127) res = 24'sd127;
                else if (inval_reg < -16'sd128) res = -24'sd128;
                else res = 24'(inval_reg);
                load_cls = 1'b1; wr_rd = 1'b1;
            end
            OP_STD:
            begin
                if (!dir_ok) err = ERR_BAD_ADDR;
            end
            OP_STI:
            begin
                if (!ind_ok) err = ERR_BAD_ADDR;
            end
            OP_PUSH:
            begin
                if (sp_reg >= SP_W'(STACK_DEPTH)) err = ERR_STACK_OVER;
            end
            OP_POP:
            begin
                if (sp_reg == SP_W'(0)) err = ERR_STACK_UNDER;
                res = 24'($signed(stk_rd)); load_cls = 1'b1; wr_rd = 1'b1;
            end
            default:
            begin
                res = 24'sd0;
            end
        endcase
    end
    assign sum9 = {1'b0, a_reg} + {1'b0, bop};

    // control registers: sweep pointer, stack count, PC, flags, error, halt, display, register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg         <= '0;
            sp_reg          <= '0;
            program_counter <= 16'd0;
            carry_flag      <= 1'b0;
            zero_flag       <= 1'b0;
            overflow_flag   <= 1'b0;
            underflow_flag  <= 1'b0;
            error_code      <= ERR_NONE;
            halted          <= 1'b0;
            display_valid   <= 1'b0;
            display_value   <= 8'sd0;
            for (int i = 0; i < NUM_REGS; i++) rf_reg[i] <= 8'sd0;
        end
        else
        begin
            if (cmd.clear_step && clr_busy)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.commit)
            begin
                display_valid <= show;
                display_value <= show ? a_reg : 8'sd0;
                if (!halted)
                begin
                    if (err != ERR_NONE)
                    begin
                        error_code <= err;
                        halted     <= 1'b1;
                    end
                    else
                    begin
                        program_counter <= program_counter + 16'd1;
                        if (wr_rd) rf_reg[rd_reg] <= res[7:0];
                        if (set_f || load_cls)
                        begin
                            zero_flag      <= (res[7:0] == 8'd0);
                            overflow_flag  <= set_f | (op_reg == OP_MOVIMM) ? (res > 24'sd127) : 1'b0;
                            underflow_flag <= set_f | (op_reg == OP_MOVIMM) ? (res < -24'sd128) : 1'b0;
                            carry_flag     <= set_f ? sum9[8] : 1'b0;
                        end
                        if (op_reg == OP_RESET)
                        begin
                            case (fsel_reg)
                                2'd0: carry_flag <= 1'b0;
                                2'd1: zero_flag <= 1'b0;
                                2'd2: overflow_flag <= 1'b0;
                                default: underflow_flag <= 1'b0;
                            endcase
                        end
                        if (op_reg == OP_PUSH) sp_reg <= sp_reg + SP_W'(1);
                        if (op_reg == OP_POP)  sp_reg <= sp_reg - SP_W'(1);
                    end
                end
            end
        end
    end

    // operand capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= op;
            rd_reg    <= dest_reg;
            amt_reg   <= shift_amount;
            fsel_reg  <= flag_select;
            inval_reg <= input_value;
            imm_reg   <= imm;
            maddr_reg <= mem_addr;
            a_reg     <= rf_reg[dest_reg];
            ind_reg   <= rf_reg[src_reg];
            if (op == OP_MOVRR) b_reg <= 16'(rf_reg[src_reg]);
            else b_reg <= use_imm ? imm : 16'(rf_reg[src_reg]);
        end
    end
endmodule

// File: hw/rtl/t8cpu_ctrl.sv
// Controller FSM: memory clear, handshake, memory read slot, divider wait, commit, result hold.
// Depends on t8cpu_pkg.
module t8cpu_ctrl
    import t8cpu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);
    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_DIV, S_EXEC, S_OUT} state_t;
    state_t state_reg;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd.capture    = (state_reg == S_IDLE) && in_valid;
        cmd.div_start  = (state_reg == S_READ) && stat.is_div;
        cmd.commit     = (state_reg == S_EXEC);
        cmd.clear_step = (state_reg == S_CLEAR);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            out_valid <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_CLEAR: if (stat.clear_done) state_reg <= S_IDLE;
                S_IDLE:  if (in_valid) state_reg <= S_READ;
                S_READ:  state_reg <= stat.is_div ? S_DIV : S_EXEC;
                S_DIV:   if (!stat.div_busy) state_reg <= S_EXEC;
                S_EXEC:
                begin
                    state_reg <= S_OUT;
                    out_valid <= 1'b1;
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        out_valid <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_stall_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (state_reg != S_IDLE)) else $error("stall mismatch");
    a_out_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == S_EXEC) else $error("bad out");
    a_no_cap_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !cmd.capture) else $error("capture while busy");
endmodule

// File: hw/rtl/tiny_8bit_cpu_execute_unit.sv
// Top level of the tiny 8-bit CPU execute unit.
// Depends on t8cpu_pkg, t8cpu_ctrl, t8cpu_datapath.
//
//  channel | handshake             | payload
//  in      | in_valid / in_stall   | op .. input_value
//  out     | out_valid / out_stall | display_valid .. program_counter
//
// Flow: each transaction passes the capture, memory read, commit and result
// states; div adds a wait while the serial divider runs one quotient bit per cycle.
// Reset: a clearing pass over all MEM_DEPTH (64) words zeroes the data
// memory, and in_stall stays high until it is done. One transaction in flight
// at a time; out_stall holds the result and the input stays stalled.
module tiny_8bit_cpu_execute_unit
    import t8cpu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [4:0]         op,
    input  logic [2:0]         dest_reg,
    input  logic [2:0]         src_reg,
    input  logic               use_imm,
    input  logic signed [15:0] imm,
    input  logic [7:0]         mem_addr,
    input  logic [3:0]         shift_amount,
    input  logic [1:0]         flag_select,
    input  logic signed [15:0] input_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               display_valid,
    output logic signed [7:0]  display_value,
    output logic               carry_flag,
    output logic               zero_flag,
    output logic               overflow_flag,
    output logic               underflow_flag,
    output logic [2:0]         error_code,
    output logic               halted,
    output logic [15:0]        program_counter
);
    dp_cmd_t  cmd;
    dp_stat_t stat;

    t8cpu_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .stat(stat)
    );

    t8cpu_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .op(op), .dest_reg(dest_reg), .src_reg(src_reg), .use_imm(use_imm),
        .imm(imm), .mem_addr(mem_addr), .shift_amount(shift_amount),
        .flag_select(flag_select), .input_value(input_value),
        .display_valid(display_valid), .display_value(display_value),
        .carry_flag(carry_flag), .zero_flag(zero_flag),
        .overflow_flag(overflow_flag), .underflow_flag(underflow_flag),
        .error_code(error_code), .halted(halted),
        .program_counter(program_counter)
    );
endmodule
